// ===== sv/local_alignment_lane_scorer_defines.svh =====
// Assertion macros for the local alignment lane scorer.
// Used by the top level only; expects a clock i_clk and a reset i_rst_n in scope.
`ifndef LOCAL_ALIGNMENT_LANE_SCORER_DEFINES_SVH
`define LOCAL_ALIGNMENT_LANE_SCORER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LALS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LALS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lals_pkg.sv =====
// Shared types and constants of the local alignment lane scorer.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package lals_pkg;

    localparam int LANES_DEF         = 16;
    localparam int QUERY_MAX_DEF     = 64;
    localparam int RESIDUE_CODES_DEF = 32;

    localparam int SCORE_W = 16;
    localparam int CALC_W  = 18;

    // item opcodes
    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_SUBST = 2'd1;
    localparam logic [1:0] OP_SCORE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_GAP_BOUNDARY = 2'd0;
    localparam logic [1:0] CFG_GAP_INTERIOR = 2'd1;
    localparam logic [1:0] CFG_QUERY_LENGTH = 2'd2;
    localparam logic [1:0] CFG_LOCAL_MODE   = 2'd3;

    localparam logic [7:0] GAP_BOUNDARY_RST = 8'd1;
    localparam logic [7:0] GAP_INTERIOR_RST = 8'd11;
    localparam logic [6:0] QUERY_LENGTH_RST = 7'd20;
    localparam logic       LOCAL_MODE_RST   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clr;     // reset sweep of the column memory
        logic take;    // input transfer this cycle
        logic issue;   // issue one row into the cell pipeline
        logic finish;  // write back lane best, push result if sequence ends
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_score;    // offered item is a scoring item for a valid lane
        logic in_zero;     // scoring item with no rows to walk
        logic issue_last;
        logic pipe_busy;
        logic can_finish;
    } t_status;

endpackage

`default_nettype wire

// ===== sv/lals_ctrl.sv =====
// Controller of the local alignment lane scorer: sequences reset clear,
// item accept, row issue, pipeline drain and result emit. Uses lals_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lals_ctrl
    import lals_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    input  t_status i_st,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_st.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_st.in_score) begin
                    n_state = i_st.in_zero ? ST_EMIT : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (i_st.issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_st.pipe_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_st.can_finish) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/lals_dp.sv =====
// Datapath of the local alignment lane scorer: config registers, query,
// substitution and column memories, cell pipeline, lane bests, result register.
// Uses lals_pkg; driven by lals_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module lals_dp
    import lals_pkg::*;
#(
    parameter int LANES         = LANES_DEF,
    parameter int QUERY_MAX     = QUERY_MAX_DEF,
    parameter int RESIDUE_CODES = RESIDUE_CODES_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire  [1:0]                i_cfg_index,
    input  wire  [7:0]                i_cfg_data,
    input  wire  [1:0]                i_op,
    input  wire  [3:0]                i_lane,
    input  wire  [5:0]                i_position,
    input  wire  [4:0]                i_query_code,
    input  wire  [4:0]                i_residue,
    input  wire  signed [7:0]         i_subst_value,
    input  wire                       i_seq_start,
    input  wire                       i_seq_end,
    input  wire                       i_out_stall,
    input  t_cmd                      i_cmd,
    output t_status                   o_st,
    output logic                      o_out_valid,
    output logic [3:0]                o_result_lane,
    output logic signed [SCORE_W-1:0] o_best_score
);

    localparam int LIW   = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int QAW   = $clog2(QUERY_MAX);
    localparam int RW    = $clog2(QUERY_MAX + 1);
    localparam int CDEP  = LANES * QUERY_MAX;
    localparam int CAW   = (CDEP > 1) ? $clog2(CDEP) : 1;
    localparam int SDEP  = RESIDUE_CODES * RESIDUE_CODES;
    localparam int SAW   = $clog2(SDEP);

    // configuration
    logic [7:0] r_gap_b, r_gap_i;
    logic [6:0] r_qlen;
    logic       r_local;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_b <= GAP_BOUNDARY_RST;
            r_gap_i <= GAP_INTERIOR_RST;
            r_qlen  <= QUERY_LENGTH_RST;
            r_local <= LOCAL_MODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAP_BOUNDARY: r_gap_b <= i_cfg_data;
                CFG_GAP_INTERIOR: r_gap_i <= i_cfg_data;
                CFG_QUERY_LENGTH: r_qlen  <= i_cfg_data[6:0];
                CFG_LOCAL_MODE:   r_local <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // memories
    logic [4:0]                query_mem [QUERY_MAX];
    logic signed [7:0]         subst_mem [SDEP];
    logic signed [SCORE_W-1:0] col_mem   [CDEP];

    // offered item decode
    logic          w_lane_ok, w_pos_ok, w_codes_ok;
    logic [LIW-1:0] w_lane_idx;
    logic [RW-1:0] w_rows, w_npass;
    logic [SAW-1:0] w_ld_addr;

    assign w_lane_ok  = 32'(i_lane) < LANES;
    assign w_pos_ok   = 32'(i_position) < QUERY_MAX;
    assign w_codes_ok = (32'(i_query_code) < RESIDUE_CODES) && (32'(i_residue) < RESIDUE_CODES);
    assign w_lane_idx = LIW'(i_lane);
    assign w_rows     = (32'(r_qlen) < QUERY_MAX) ? RW'(r_qlen) : RW'(QUERY_MAX);
    assign w_npass    = i_seq_start ? RW'(QUERY_MAX) : w_rows;
    assign w_ld_addr  = SAW'(i_query_code) * SAW'(RESIDUE_CODES) + SAW'(i_residue);

    // item registers
    logic [LIW-1:0]            r_lane;
    logic [4:0]                r_rc;
    logic                      r_start, r_end;
    logic [RW-1:0]             r_rows, r_npass, r_row;
    logic signed [SCORE_W-1:0] r_best;
    logic signed [SCORE_W-1:0] r_lane_best [LANES];
    logic [CAW-1:0]            r_clr;

    // pipeline
    logic                      r_s1_v, r_s2_v, r_s3_v;
    logic [RW-1:0]             r_s1_row, r_s2_row;
    logic [4:0]                r_qs_q;
    logic signed [SCORE_W-1:0] r_col_q, r_s2_left;
    logic signed [7:0]         r_sub_q;
    logic                      r_s2_ok;
    logic signed [SCORE_W-1:0] r_up, r_diag, r_s3_m;
    logic                      r_s3_cmp;

    logic [CAW-1:0] w_rd_addr, w_wr_addr;
    logic [SAW-1:0] w_sub_addr;

    assign w_rd_addr  = CAW'(r_lane) * CAW'(QUERY_MAX) + CAW'(r_row);
    assign w_wr_addr  = CAW'(r_lane) * CAW'(QUERY_MAX) + CAW'(r_s2_row);
    assign w_sub_addr = SAW'(r_qs_q) * SAW'(RESIDUE_CODES) + SAW'(r_rc);

    // cell compute
    logic                      w_comp;
    logic signed [7:0]         w_sub;
    logic signed [CALC_W-1:0]  w_c, w_a, w_b, w_max, w_flr;
    logic signed [SCORE_W-1:0] w_m;
    logic [7:0]                w_up_gap, w_left_gap;

    always_comb begin
        w_comp     = r_s2_row < r_rows;
        w_sub      = r_s2_ok ? r_sub_q : '0;
        w_up_gap   = (r_s2_row == '0) ? r_gap_b : r_gap_i;
        w_left_gap = r_start ? r_gap_b : r_gap_i;
        w_c   = CALC_W'(r_diag) + CALC_W'(w_sub);
        w_a   = CALC_W'(r_up) - $signed(CALC_W'(w_up_gap));
        w_b   = CALC_W'(r_s2_left) - $signed(CALC_W'(w_left_gap));
        w_max = w_c;
        if (w_a > w_max) begin
            w_max = w_a;
        end
        if (w_b > w_max) begin
            w_max = w_b;
        end
        w_flr = (r_local && (w_max < 0)) ? '0 : w_max;
        if (w_flr > CALC_W'(32767)) begin
            w_m = 16'sh7FFF;
        end else if (w_flr < -CALC_W'(32768)) begin
            w_m = 16'sh8000;
        end else begin
            w_m = w_flr[SCORE_W-1:0];
        end
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_op == OP_QUERY) && w_pos_ok) begin
            query_mem[QAW'(i_position)] <= i_query_code;
        end
        r_qs_q <= query_mem[r_row[QAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_op == OP_SUBST) && w_codes_ok) begin
            subst_mem[w_ld_addr] <= i_subst_value;
        end
        r_sub_q <= subst_mem[w_sub_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            col_mem[r_clr] <= '0;
        end else if (r_s2_v) begin
            col_mem[w_wr_addr] <= w_comp ? w_m : '0;
        end
        r_col_q <= col_mem[w_rd_addr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s1_row  <= r_row;
        r_s2_row  <= r_s1_row;
        r_s2_left <= r_start ? '0 : r_col_q;
        r_s2_ok   <= (32'(r_qs_q) < RESIDUE_CODES) && (32'(r_rc) < RESIDUE_CODES);
        r_s3_m    <= w_m;
        if (i_cmd.take && w_lane_ok && (i_op == OP_SCORE)) begin
            r_lane  <= w_lane_idx;
            r_rc    <= i_residue;
            r_start <= i_seq_start;
            r_end   <= i_seq_end;
            r_rows  <= w_rows;
            r_npass <= w_npass;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_row       <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_s3_cmp    <= 1'b0;
            r_up        <= '0;
            r_diag      <= '0;
            r_best      <= '0;
            o_out_valid <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                r_lane_best[i] <= '0;
            end
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + 1'b1;
            end
            r_s1_v   <= i_cmd.issue;
            r_s2_v   <= r_s1_v;
            r_s3_v   <= r_s2_v;
            r_s3_cmp <= r_s2_v && w_comp;
            if (i_cmd.take && o_st.in_score) begin
                r_row  <= '0;
                r_up   <= '0;
                r_diag <= '0;
                r_best <= i_seq_start ? '0 : r_lane_best[w_lane_idx];
            end else begin
                if (i_cmd.issue) begin
                    r_row <= r_row + 1'b1;
                end
                if (r_s2_v && w_comp) begin
                    r_up   <= w_m;
                    r_diag <= r_s2_left;
                end
                if (r_s3_cmp && (r_s3_m > r_best)) begin
                    r_best <= r_s3_m;
                end
            end
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_lane_best[r_lane] <= r_best;
                if (r_end) begin
                    o_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_end) begin
            o_result_lane <= 4'(r_lane);
            o_best_score  <= r_best;
        end
    end

    always_comb begin
        o_st.clr_last   = r_clr == CAW'(CDEP - 1);
        o_st.in_score   = (i_op == OP_SCORE) && w_lane_ok;
        o_st.in_zero    = w_npass == '0;
        o_st.issue_last = r_row == (r_npass - 1'b1);
        o_st.pipe_busy  = r_s1_v || r_s2_v || r_s3_v || r_s3_cmp;
        o_st.can_finish = !r_end || !o_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire

// ===== sv/local_alignment_lane_scorer.sv =====
// Local alignment lane scorer: scores up to LANES database sequences against
// one stored query with a linear gap. Query loads and substitution loads are
// written while idle and do not leave the idle state. A scoring item walks
// its lane's column one query row per cycle through a four-stage cell
// pipeline (query read, substitution read, cell compute and write back, best
// update), over rows = min(query_length, QUERY_MAX) rows, or QUERY_MAX rows when
// it opens a sequence, since the rest of the column is zeroed in the same walk.
// One item is in flight at a time. After reset all LANES * QUERY_MAX entries
// of the column memory are swept to zero while input stays stalled; config
// writes are taken at any time and must only come while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "local_alignment_lane_scorer_defines.svh"

module local_alignment_lane_scorer
    import lals_pkg::*;
#(
    parameter int LANES         = LANES_DEF,
    parameter int QUERY_MAX     = QUERY_MAX_DEF,
    parameter int RESIDUE_CODES = RESIDUE_CODES_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire  [1:0]                i_cfg_index,
    input  wire  [7:0]                i_cfg_data,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire  [1:0]                i_op,
    input  wire  [3:0]                i_lane,
    input  wire  [5:0]                i_position,
    input  wire  [4:0]                i_query_code,
    input  wire  [4:0]                i_residue,
    input  wire  signed [7:0]         i_subst_value,
    input  wire                       i_seq_start,
    input  wire                       i_seq_end,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output logic [3:0]                o_result_lane,
    output logic signed [SCORE_W-1:0] o_best_score
);

    t_cmd    w_cmd;
    t_status w_st;

    assign o_cfg_ready = 1'b1;

    lals_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (w_st),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    lals_dp #(
        .LANES         (LANES),
        .QUERY_MAX     (QUERY_MAX),
        .RESIDUE_CODES (RESIDUE_CODES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_lane        (i_lane),
        .i_position    (i_position),
        .i_query_code  (i_query_code),
        .i_residue     (i_residue),
        .i_subst_value (i_subst_value),
        .i_seq_start   (i_seq_start),
        .i_seq_end     (i_seq_end),
        .i_out_stall   (i_out_stall),
        .i_cmd         (w_cmd),
        .o_st          (w_st),
        .o_out_valid   (o_out_valid),
        .o_result_lane (o_result_lane),
        .o_best_score  (o_best_score)
    );

    // a scoring transfer makes the block busy on the next cycle
    `LALS_ASSERT_NXT(a_busy_after_score, i_in_valid && !o_in_stall && w_st.in_score, o_in_stall, "input not stalled while scoring")
    // a new result only appears at the end of a busy item
    `LALS_ASSERT_IMP(a_result_from_item, $rose(o_out_valid), $past(o_in_stall), "result without item")
    // lane best is written back only after the cell pipeline drained
    `LALS_ASSERT_IMP(a_finish_drained, w_cmd.finish, !w_st.pipe_busy, "finish with cells in flight")

endmodule

`default_nettype wire
